[hw/rtl/qws_pkg.sv]
// Shared types, codes and character helpers for the quoted word splitter.
// No dependencies; every other file of the block imports this package.
package qws_pkg;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_DOUBLE = 2'd1,
        QUOTE_SINGLE = 2'd2
    } t_quote;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ESC_AT_END = 2'd1,
        ST_OPEN_DQ    = 2'd2,
        ST_OPEN_SQ    = 2'd3
    } t_status;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } t_op;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_out;
        logic       word_done;
        logic       line_done;
        t_status    status;
        logic [7:0] word_count;
    } t_result;

    // Space, TAB, LF, VT, FF, CR.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] esc_xlate(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_LOW_T) r = CH_TAB;
        else if (c == CH_LOW_N) r = CH_LF;
        else if (c == CH_LOW_B) r = CH_BS;
        else if (c == CH_LOW_R) r = CH_CR;
        return r;
    endfunction

endpackage

[hw/rtl/qws_in_reg.sv]
// Input register of the quoted word splitter: holds one accepted beat.
// Depends on qws_pkg for the op code type.
module qws_in_reg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  qws_pkg::t_op i_op,
    input  logic [7:0]   i_char,
    input  logic         i_take,
    output logic         o_valid,
    output qws_pkg::t_op o_op,
    output logic [7:0]   o_char
);
    import qws_pkg::*;

    logic r_valid;
    t_op  r_op;
    logic [7:0] r_char;
    logic load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op   <= i_op;
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_char  = r_char;
endmodule

[hw/rtl/qws_parse.sv]
// Tokenizer state and single-pass next-state logic for one byte or end of line.
// Depends on qws_pkg for codes, the result struct and character helpers.
module qws_parse #(
    parameter logic [7:0] COUNT_LIM = 8'd255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  qws_pkg::t_op     i_op,
    input  logic [7:0]       i_char,
    output logic             o_emit,
    output qws_pkg::t_result o_result
);
    import qws_pkg::*;

    t_quote     r_quote, n_quote;
    logic       r_esc, n_esc;
    logic       r_start, n_start;
    logic       r_run, n_run;
    logic       r_open, n_open;
    logic [7:0] r_words, n_words;
    logic [7:0] bumped;

    assign bumped = (r_words < COUNT_LIM) ? r_words + 8'd1 : r_words;

    always_comb begin
        n_quote = r_quote;
        n_esc   = r_esc;
        n_start = r_start;
        n_run   = r_run;
        n_open  = r_open;
        n_words = r_words;
        o_emit  = 1'b0;
        o_result = '{has_char: 1'b0, char_out: 8'd0, word_done: 1'b0,
                     line_done: 1'b0, status: ST_OK, word_count: r_words};

        if (i_op == OP_EOL) begin
            o_emit             = 1'b1;
            o_result.line_done = 1'b1;
            if (r_esc) begin
                o_result.status = ST_ESC_AT_END;
            end else if (r_quote == QUOTE_DOUBLE) begin
                o_result.status = ST_OPEN_DQ;
            end else if (r_quote == QUOTE_SINGLE) begin
                o_result.status = ST_OPEN_SQ;
            end else if (r_open) begin
                o_result.word_done  = 1'b1;
                o_result.word_count = bumped;
            end
            // Back to the start of a fresh line.
            n_quote = QUOTE_NONE;
            n_esc   = 1'b0;
            n_start = 1'b1;
            n_run   = 1'b0;
            n_open  = 1'b0;
            n_words = 8'd0;
        end else if (r_esc) begin
            n_esc             = 1'b0;
            n_open            = 1'b1;
            o_emit            = 1'b1;
            o_result.has_char = 1'b1;
            o_result.char_out = esc_xlate(i_char);
        end else if (r_quote == QUOTE_NONE && is_blank(i_char)) begin
            // Only the first blank of a run after a word closes it.
            if (!r_start && !r_run) begin
                n_run               = 1'b1;
                n_open              = 1'b0;
                n_words             = bumped;
                o_emit              = 1'b1;
                o_result.word_done  = 1'b1;
                o_result.word_count = bumped;
            end
        end else begin
            n_start = 1'b0;
            n_run   = 1'b0;
            if (i_char == CH_BSLASH) begin
                n_esc = 1'b1;
            end else if ((r_quote == QUOTE_DOUBLE && i_char == CH_DQUOTE) ||
                         (r_quote == QUOTE_SINGLE && i_char == CH_SQUOTE)) begin
                n_quote = QUOTE_NONE;
            end else if (r_quote == QUOTE_NONE &&
                         (i_char == CH_DQUOTE || i_char == CH_SQUOTE)) begin
                n_quote = (i_char == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
                n_open  = 1'b1;
            end else begin
                n_open            = 1'b1;
                o_emit            = 1'b1;
                o_result.has_char = 1'b1;
                o_result.char_out = i_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QUOTE_NONE;
            r_esc   <= 1'b0;
            r_start <= 1'b1;
            r_run   <= 1'b0;
            r_open  <= 1'b0;
            r_words <= 8'd0;
        end else if (i_go) begin
            r_quote <= n_quote;
            r_esc   <= n_esc;
            r_start <= n_start;
            r_run   <= n_run;
            r_open  <= n_open;
            r_words <= n_words;
        end
    end
endmodule

[hw/rtl/qws_out_reg.sv]
// Result register of the quoted word splitter: holds one result beat for the sink.
// Depends on qws_pkg for the result struct.
module qws_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  qws_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output qws_pkg::t_result o_result
);
    import qws_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held beat leaves this cycle.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

[hw/rtl/quoted_word_splitter.sv]
// Shell-style word splitter: turns a byte stream into words, one byte per beat.
// Top level; instantiates qws_in_reg, qws_parse and qws_out_reg, uses qws_pkg.
//
// Each input beat is a byte or an end-of-line marker; it passes through an input
// register, one stage of flag logic and a result register, so one beat is taken
// every cycle while the sink keeps up. Quotes, escape backslashes and skipped
// whitespace give no result beat. The end-of-line beat always gives a result
// with the line status and word count, and clears the tokenizer for the next
// line. The count saturates at the smaller of MAX_WORDS and 255.
module quoted_word_splitter #(
    parameter int MAX_WORDS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_has_char,
    output logic [7:0] o_char_out,
    output logic       o_word_done,
    output logic       o_line_done,
    output logic [1:0] o_status,
    output logic [7:0] o_word_count
);
    import qws_pkg::*;

    localparam int         CountLimInt = (MAX_WORDS > 255) ? 255 : MAX_WORDS;
    localparam logic [7:0] CountLim    = 8'(CountLimInt);

    logic       st_valid;
    t_op        st_op;
    logic [7:0] st_char;
    logic       go;
    logic       emit;
    logic       out_free;
    t_result    res;
    t_result    out_res;

    // Advance the staged beat whenever the result register can take its outcome.
    assign go = st_valid && out_free;

    qws_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_op    (t_op'(i_op)),
        .i_char  (i_char_code),
        .i_take  (go),
        .o_valid (st_valid),
        .o_op    (st_op),
        .o_char  (st_char)
    );

    qws_parse #(
        .COUNT_LIM (CountLim)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_op     (st_op),
        .i_char   (st_char),
        .o_emit   (emit),
        .o_result (res)
    );

    qws_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go && emit),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_res)
    );

    assign o_has_char   = out_res.has_char;
    assign o_char_out   = out_res.char_out;
    assign o_word_done  = out_res.word_done;
    assign o_line_done  = out_res.line_done;
    assign o_status     = out_res.status;
    assign o_word_count = out_res.word_count;

    a_char_not_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_char |-> !o_word_done && !o_line_done)
        else $error("char beat also marks a boundary");

    a_error_only_at_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_line_done && !o_word_done)
        else $error("error status outside a clean end of line");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_word_count <= CountLim)
        else $error("word count beyond its limit");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_valid && !out_free |=> st_valid && $stable(st_char) && $stable(st_op))
        else $error("staged beat lost while the result register is full");
endmodule
